// ===== hw/rtl/tcw_pkg.sv =====
package tcw_pkg;

   localparam int unsigned COL_W  = 7;
   localparam int unsigned ROW_W  = 8;
   localparam int unsigned ADDR_W = 15;
   localparam int unsigned VAL_W  = 16;
   localparam int unsigned CHAR_W = 8;
   localparam int unsigned ATTR_W = 8;

   localparam logic [CHAR_W-1:0] CHAR_CR = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_LF = 8'd10;

   localparam logic [7:0] REG_CURSOR_HI = 8'h0e;
   localparam logic [7:0] REG_CURSOR_LO = 8'h0f;
   localparam logic [7:0] REG_START_HI  = 8'h0c;
   localparam logic [7:0] REG_START_LO  = 8'h0d;

   localparam logic [ADDR_W-1:0] PORT_INDEX = 15'h3d4;
   localparam logic [ADDR_W-1:0] PORT_DATA  = 15'h3d5;

   localparam logic KIND_CELL = 1'b0;
   localparam logic KIND_PORT = 1'b1;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

   // one classified character, as handed from front to back
   typedef struct packed {
      logic              has_cell;
      logic [ADDR_W-1:0] cell_idx;
      logic [VAL_W-1:0]  cell_val;
      logic [ADDR_W-1:0] cursor_addr;
      logic              scroll;
      logic [ADDR_W-1:0] start_addr;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ===== hw/rtl/tcw_req_if.sv =====
interface tcw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

// ===== hw/rtl/tcw_rsp_if.sv =====
interface tcw_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [14:0] target;
   logic [15:0] value;
   logic        last;

   modport source (output valid, output kind, output target, output value, output last,
                   input ready);
   modport sink   (input valid, input kind, input target, input value, input last,
                   output ready);
endinterface

// ===== hw/rtl/tcw_csr_if.sv =====
interface tcw_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_attribute;

   modport source (output valid, output text_attribute, input ready);
   modport sink   (input valid, input text_attribute, output ready);
endinterface

// ===== hw/rtl/tcw_front.sv =====
module tcw_front #(
   parameter int unsigned COLS_PER_LINE = 80,
   parameter int unsigned VISIBLE_ROWS  = 25
) (
   input  logic                            clock,
   input  logic                            reset,
   tcw_req_if.sink                         req_if,
   input  logic [tcw_pkg::ATTR_W-1:0]      attr,
   input  tcw_pkg::q_stat_type             q_stat,
   output logic                            push,
   output tcw_pkg::desc_type               desc
);

   localparam logic [tcw_pkg::ADDR_W-1:0] COLS_A   = tcw_pkg::ADDR_W'(COLS_PER_LINE);
   localparam logic [tcw_pkg::COL_W-1:0]  COL_LAST = tcw_pkg::COL_W'(COLS_PER_LINE - 1);
   localparam logic [tcw_pkg::ROW_W-1:0]  ROWS_R   = tcw_pkg::ROW_W'(VISIBLE_ROWS);
   localparam logic [tcw_pkg::COL_W-1:0]  COL_ONE  = tcw_pkg::COL_W'(1);
   localparam logic [tcw_pkg::ROW_W-1:0]  ROW_ONE  = tcw_pkg::ROW_W'(1);

   logic [tcw_pkg::COL_W-1:0] col_ff, col_in;
   logic [tcw_pkg::ROW_W-1:0] row_ff, row_in;
   logic [tcw_pkg::ROW_W-1:0] scroll_rows;
   logic                      is_cr, is_lf;

   assign req_if.ready = !q_stat.full;
   assign push         = req_if.valid && !q_stat.full;

   assign is_cr = (req_if.char_code == tcw_pkg::CHAR_CR);
   assign is_lf = (req_if.char_code == tcw_pkg::CHAR_LF);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (is_cr) begin
         col_in = '0;
      end else if (is_lf) begin
         row_in = row_ff + ROW_ONE;
      end else if (col_ff < COL_LAST) begin
         col_in = col_ff + COL_ONE;
      end else begin
         col_in = '0;
         row_in = row_ff + ROW_ONE;
      end
   end

   // rows scrolled off the top, valid when the row is past the screen
   assign scroll_rows = row_in - ROWS_R + ROW_ONE;

   always_comb begin
      desc.has_cell    = !is_cr && !is_lf;
      desc.cell_idx    = tcw_pkg::ADDR_W'(row_ff) * COLS_A + tcw_pkg::ADDR_W'(col_ff);
      desc.cell_val    = {attr, req_if.char_code};
      desc.cursor_addr = tcw_pkg::ADDR_W'(row_in) * COLS_A + tcw_pkg::ADDR_W'(col_in);
      desc.scroll      = (row_in >= ROWS_R);
      desc.start_addr  = tcw_pkg::ADDR_W'(scroll_rows) * COLS_A;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (push) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== hw/rtl/tcw_queue.sv =====
module tcw_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tcw_pkg::desc_type   push_desc,
   input  logic                pop,
   output tcw_pkg::desc_type   head,
   output tcw_pkg::q_stat_type q_stat
);

   tcw_pkg::desc_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   assign head         = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == 2'd2);
   assign q_stat.empty = (count_ff == 2'd0);

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== hw/rtl/tcw_back.sv =====
module tcw_back (
   input  logic                clock,
   input  logic                reset,
   input  tcw_pkg::desc_type   head,
   input  tcw_pkg::q_stat_type q_stat,
   output logic                pop,
   tcw_rsp_if.source           rsp_if
);

   localparam logic [3:0] ST_CELL   = 4'd0;
   localparam logic [3:0] ST_CI_IDX = 4'd1;
   localparam logic [3:0] ST_CI_HI  = 4'd2;
   localparam logic [3:0] ST_CL_IDX = 4'd3;
   localparam logic [3:0] ST_CL_LO  = 4'd4;
   localparam logic [3:0] ST_SH_IDX = 4'd5;
   localparam logic [3:0] ST_SH_HI  = 4'd6;
   localparam logic [3:0] ST_SL_IDX = 4'd7;
   localparam logic [3:0] ST_SL_LO  = 4'd8;

   logic [3:0]                 step_ff, step_in, cur_step;
   logic                       valid_ff, valid_in;
   logic                       kind_ff, kind_in;
   logic [tcw_pkg::ADDR_W-1:0] target_ff, target_in;
   logic [tcw_pkg::VAL_W-1:0]  value_ff, value_in;
   logic                       last_ff, last_in;
   logic                       load;

   assign load     = !q_stat.empty && (!valid_ff || rsp_if.ready);
   assign cur_step = (step_ff == ST_CELL && !head.has_cell) ? ST_CI_IDX : step_ff;

   always_comb begin
      kind_in   = tcw_pkg::KIND_PORT;
      target_in = tcw_pkg::PORT_INDEX;
      value_in  = '0;
      last_in   = 1'b0;
      case (cur_step)
         ST_CELL: begin
            kind_in   = tcw_pkg::KIND_CELL;
            target_in = head.cell_idx;
            value_in  = head.cell_val;
         end
         ST_CI_IDX: value_in = tcw_pkg::VAL_W'(tcw_pkg::REG_CURSOR_HI);
         ST_CI_HI: begin
            target_in = tcw_pkg::PORT_DATA;
            value_in  = tcw_pkg::VAL_W'(head.cursor_addr[14:8]);
         end
         ST_CL_IDX: value_in = tcw_pkg::VAL_W'(tcw_pkg::REG_CURSOR_LO);
         ST_CL_LO: begin
            target_in = tcw_pkg::PORT_DATA;
            value_in  = tcw_pkg::VAL_W'(head.cursor_addr[7:0]);
            last_in   = !head.scroll;
         end
         ST_SH_IDX: value_in = tcw_pkg::VAL_W'(tcw_pkg::REG_START_HI);
         ST_SH_HI: begin
            target_in = tcw_pkg::PORT_DATA;
            value_in  = tcw_pkg::VAL_W'(head.start_addr[14:8]);
         end
         ST_SL_IDX: value_in = tcw_pkg::VAL_W'(tcw_pkg::REG_START_LO);
         ST_SL_LO: begin
            target_in = tcw_pkg::PORT_DATA;
            value_in  = tcw_pkg::VAL_W'(head.start_addr[7:0]);
            last_in   = 1'b1;
         end
         default: begin
            last_in = 1'b1;
         end
      endcase
   end

   assign pop     = load && last_in;
   assign step_in = !load ? step_ff : (last_in ? ST_CELL : cur_step + 4'd1);

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= ST_CELL;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= kind_in;
         target_ff <= target_in;
         value_ff  <= value_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_if.valid  = valid_ff;
   assign rsp_if.kind   = kind_ff;
   assign rsp_if.target = target_ff;
   assign rsp_if.value  = value_ff;
   assign rsp_if.last   = last_ff;

endmodule

// ===== hw/rtl/text_console_char_writer.sv =====
// channel | dir | payload                              | transfer when
// req_if  | in  | char_code[7:0]                       | valid && ready
// rsp_if  | out | kind, target[14:0], value[15:0], last | valid && ready
// csr_if  | in  | text_attribute[7:0]                  | valid && ready (ready always high)
//
// each character gives 4 to 9 results, one per cycle while the receiver holds ready high;
// throughput is set by the result sequencer and its output register
// reset (synchronous, active high) puts the cursor at column 0 row 0, the attribute
// at 7 and empties the two-entry queue
// the front keeps taking characters while the back is stalled, until the queue fills
module text_console_char_writer #(
   parameter int unsigned COLS_PER_LINE = 80,
   parameter int unsigned VISIBLE_ROWS  = 25
) (
   input  logic      clock,
   input  logic      reset,
   tcw_req_if.sink   req_if,
   tcw_rsp_if.source rsp_if,
   tcw_csr_if.sink   csr_if
);

   // attribute register, to be written only while idle; the block itself does not enforce it
   logic [tcw_pkg::ATTR_W-1:0] attr_ff, attr_in;

   // front to queue
   logic                push;
   tcw_pkg::desc_type   push_desc;

   // queue to back
   tcw_pkg::desc_type   head;
   tcw_pkg::q_stat_type q_stat;
   logic                pop;

   assign csr_if.ready = 1'b1;
   assign attr_in      = csr_if.valid ? csr_if.text_attribute : attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tcw_pkg::ATTR_RESET;
      end else begin
         attr_ff <= attr_in;
      end
   end

   // front: classify the character, move the cursor, work out the addresses
   tcw_front #(
      .COLS_PER_LINE (COLS_PER_LINE),
      .VISIBLE_ROWS  (VISIBLE_ROWS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .attr   (attr_ff),
      .q_stat (q_stat),
      .push   (push),
      .desc   (push_desc)
   );

   // short queue decoupling front from back
   tcw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   // back: step through the cell write and the controller port writes
   tcw_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .q_stat (q_stat),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

   // a cell write is never the closing result of a character
   a_cell_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.kind == tcw_pkg::KIND_CELL |-> !rsp_if.last)
      else $error("cell write flagged last");

   // controller writes only go to the index or data port
   a_port_target: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.kind == tcw_pkg::KIND_PORT |->
         rsp_if.target == tcw_pkg::PORT_INDEX || rsp_if.target == tcw_pkg::PORT_DATA)
      else $error("port write to unknown port");

   // input is held off exactly while the queue is full
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      req_if.ready == !q_stat.full)
      else $error("input ready disagrees with queue state");

   // a result with last set pulls its entry from the queue in the cycle it is loaded
   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_if.valid && rsp_if.last)
      else $error("queue entry released without closing result");

endmodule

// ===== verif/tcw_checker.sv =====
`timescale 1ns / 1ps

module tcw_checker #(
   parameter int unsigned COLS_PER_LINE = 80,
   parameter int unsigned VISIBLE_ROWS  = 25
) (
   input  logic clock,
   input  logic reset,
   tcw_req_if   req_if,
   tcw_rsp_if   rsp_if,
   tcw_csr_if   csr_if,
   output int   fail_count,
   output int   writes_pending
);

   typedef struct packed {
      logic                       kind;
      logic [tcw_pkg::ADDR_W-1:0] target;
      logic [tcw_pkg::VAL_W-1:0]  value;
      logic                       last;
   } screen_write_type;

   screen_write_type           expected_writes[$];
   logic [tcw_pkg::COL_W-1:0]  cursor_col;
   logic [tcw_pkg::ROW_W-1:0]  cursor_row;
   logic [tcw_pkg::ATTR_W-1:0] attribute;

   task automatic push_write(input logic kind, input logic [tcw_pkg::ADDR_W-1:0] target,
                             input logic [tcw_pkg::VAL_W-1:0] value, input logic last);
      screen_write_type w;
      w.kind   = kind;
      w.target = target;
      w.value  = value;
      w.last   = last;
      expected_writes.push_back(w);
   endtask

   // index/data writes for one 16-bit controller register pair
   task automatic push_reg_pair(input logic [7:0] index_hi, input logic [7:0] index_lo,
                                input logic [15:0] addr, input logic closes);
      push_write(tcw_pkg::KIND_PORT, tcw_pkg::PORT_INDEX, {8'h00, index_hi}, 1'b0);
      push_write(tcw_pkg::KIND_PORT, tcw_pkg::PORT_DATA, {8'h00, addr[15:8]}, 1'b0);
      push_write(tcw_pkg::KIND_PORT, tcw_pkg::PORT_INDEX, {8'h00, index_lo}, 1'b0);
      push_write(tcw_pkg::KIND_PORT, tcw_pkg::PORT_DATA, {8'h00, addr[7:0]}, closes);
   endtask

   task automatic predict_char_writes(input logic [tcw_pkg::CHAR_W-1:0] ch);
      logic [15:0] cursor_addr;
      logic [15:0] start_addr;
      logic        scrolling;
      if (ch == tcw_pkg::CHAR_CR) begin
         cursor_col = '0;
      end else if (ch == tcw_pkg::CHAR_LF) begin
         cursor_row = cursor_row + 1'b1;
      end else begin
         push_write(tcw_pkg::KIND_CELL,
                    tcw_pkg::ADDR_W'(cursor_row * COLS_PER_LINE + cursor_col),
                    {attribute, ch}, 1'b0);
         if (cursor_col < COLS_PER_LINE - 1) begin
            cursor_col = cursor_col + 1'b1;
         end else begin
            cursor_col = '0;
            cursor_row = cursor_row + 1'b1;
         end
      end
      cursor_addr = 16'(cursor_row * COLS_PER_LINE + cursor_col);
      scrolling   = (cursor_row >= VISIBLE_ROWS);
      push_reg_pair(tcw_pkg::REG_CURSOR_HI, tcw_pkg::REG_CURSOR_LO, cursor_addr, !scrolling);
      if (scrolling) begin
         start_addr = 16'((cursor_row - VISIBLE_ROWS + 1) * COLS_PER_LINE);
         push_reg_pair(tcw_pkg::REG_START_HI, tcw_pkg::REG_START_LO, start_addr, 1'b1);
      end
   endtask

   task automatic report_field(input string name, input int want, input int got);
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
   endtask

   task automatic check_write();
      screen_write_type want;
      if (expected_writes.size() == 0) begin
         fail_count++;
         $display("%0t: extra result, expected none, actual kind %0d target %h value %h last %0d",
                  $time, rsp_if.kind, rsp_if.target, rsp_if.value, rsp_if.last);
      end else begin
         want = expected_writes.pop_front();
         if (rsp_if.kind !== want.kind)     report_field("kind", want.kind, rsp_if.kind);
         if (rsp_if.target !== want.target) report_field("target", want.target, rsp_if.target);
         if (rsp_if.value !== want.value)   report_field("value", want.value, rsp_if.value);
         if (rsp_if.last !== want.last)     report_field("last", want.last, rsp_if.last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cursor_col = '0;
         cursor_row = '0;
         attribute  = tcw_pkg::ATTR_RESET;
         fail_count = 0;
         expected_writes.delete();
      end else begin
         // predict before comparing, in case a result leaves in the cycle its char came in
         if (csr_if.valid && csr_if.ready) attribute = csr_if.text_attribute;
         if (req_if.valid && req_if.ready) predict_char_writes(req_if.char_code);
         if (rsp_if.valid && rsp_if.ready) check_write();
      end
      writes_pending = expected_writes.size();
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned COLS_PER_LINE = 80;
   localparam int unsigned VISIBLE_ROWS  = 25;

   // no transfer on any channel for this long means the block is hung
   localparam int STALL_LIMIT   = 1000;
   // long receiver hold-off, started once after this many result transfers
   localparam int HOLD_CYCLES   = 120;
   localparam int HOLD_AT_COUNT = 700;
   localparam int DRAIN_CYCLES  = 20;

   typedef enum int {RUN_FEED, RUN_TEXT, RUN_LINE, RUN_NOISE} run_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   writes_pending;
   int   idle_cycles = 0;
   int   chars_sent  = 0;
   int   feeds_sent  = 0;
   bit   send_quiet  = 1'b0;
   bit   take_quiet  = 1'b0;

   // opening chars under the reset attribute: cr on an empty line, byte extremes,
   // alternating bits, and the neighbors of cr and lf which are plain cells
   logic [tcw_pkg::CHAR_W-1:0] reset_attr_chars[$] = '{tcw_pkg::CHAR_CR, 8'h00, 8'hff,
                                                       tcw_pkg::CHAR_LF, tcw_pkg::CHAR_CR,
                                                       8'h55, 8'haa, 8'h0c, 8'h0e, 8'h0b,
                                                       8'h09};
   logic [tcw_pkg::CHAR_W-1:0] full_attr_chars[$]  = '{8'h20, 8'h7f, 8'h80,
                                                       tcw_pkg::CHAR_LF, tcw_pkg::CHAR_LF};
   logic [tcw_pkg::CHAR_W-1:0] zero_attr_chars[$]  = '{8'h41, tcw_pkg::CHAR_CR,
                                                       tcw_pkg::CHAR_CR, tcw_pkg::CHAR_LF,
                                                       8'h01, 8'hfe};

   tcw_req_if req_if();
   tcw_rsp_if rsp_if();
   tcw_csr_if csr_if();

   text_console_char_writer #(
      .COLS_PER_LINE(COLS_PER_LINE),
      .VISIBLE_ROWS (VISIBLE_ROWS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   // watches all three channels, predicts every result and counts mismatches
   tcw_checker #(
      .COLS_PER_LINE(COLS_PER_LINE),
      .VISIBLE_ROWS (VISIBLE_ROWS)
   ) cursor_checker (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_if),
      .rsp_if        (rsp_if),
      .csr_if        (csr_if),
      .fail_count    (fail_count),
      .writes_pending(writes_pending)
   );

   always #5 clock = ~clock;

   // watchdog: cycles in a row without a single transfer
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // any byte but cr and lf, so it always lands on the screen
   function automatic logic [tcw_pkg::CHAR_W-1:0] text_byte();
      logic [tcw_pkg::CHAR_W-1:0] ch;
      do ch = tcw_pkg::CHAR_W'($urandom);
      while (ch == tcw_pkg::CHAR_CR || ch == tcw_pkg::CHAR_LF);
      return ch;
   endfunction

   // one char transfer; called and returning at a falling edge
   task automatic send_char(input logic [tcw_pkg::CHAR_W-1:0] ch);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 3);
      // switch now and then between gappy and back-to-back stretches
      if ($urandom_range(0, 15) == 0) send_quiet = !send_quiet;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.char_code <= ch;
      req_if.valid     <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      chars_sent++;
      if (ch == tcw_pkg::CHAR_LF) feeds_sent++;
   endtask

   // attribute is only changed with the block drained
   task automatic write_attribute(input logic [tcw_pkg::ATTR_W-1:0] attr);
      req_if.valid <= 1'b0;
      while (writes_pending != 0) @(negedge clock);
      csr_if.text_attribute <= attr;
      csr_if.valid          <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // random text made of runs: mostly line feeds so the row climbs past the
   // visible rows, short text lines, long lines that wrap the column, and raw
   // noise bytes; each call opens with a long line
   task automatic send_random_text(input int min_chars, input int min_feeds);
      int           start_chars;
      int           start_feeds;
      int           pick;
      bit           opening;
      run_kind_type kind;
      start_chars = chars_sent;
      start_feeds = feeds_sent;
      opening     = 1'b1;
      while (chars_sent - start_chars < min_chars || feeds_sent - start_feeds < min_feeds) begin
         pick = $urandom_range(0, 99);
         if (opening)        kind = RUN_LINE;
         else if (pick < 60) kind = RUN_FEED;
         else if (pick < 88) kind = RUN_TEXT;
         else if (pick < 92) kind = RUN_LINE;
         else                kind = RUN_NOISE;
         opening = 1'b0;
         case (kind)
            RUN_FEED: begin
               repeat ($urandom_range(4, 20)) begin
                  if ($urandom_range(0, 15) == 0) send_char(tcw_pkg::CHAR_CR);
                  send_char(tcw_pkg::CHAR_LF);
               end
            end
            RUN_TEXT: begin
               repeat ($urandom_range(1, 12)) send_char(text_byte());
               if ($urandom_range(0, 1) == 1) send_char(tcw_pkg::CHAR_CR);
               send_char(tcw_pkg::CHAR_LF);
            end
            // at least 80 cells, so the column wraps from wherever it is
            RUN_LINE:  repeat ($urandom_range(80, 86)) send_char(text_byte());
            RUN_NOISE: repeat ($urandom_range(1, 6)) send_char(tcw_pkg::CHAR_W'($urandom));
            default: begin
            end
         endcase
      end
   endtask

   // result side: random per-result stalls, and one long hold-off so the
   // internal queue fills and the char input backs up
   initial begin : result_sink
      int gap;
      int taken;
      taken        = 0;
      rsp_if.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         rsp_if.ready <= 1'b1;
         // ready is high here, so valid at an edge means a transfer
         do @(posedge clock); while (!rsp_if.valid);
         taken++;
         @(negedge clock);
         gap = take_quiet ? 0 : $urandom_range(0, 3);
         if ($urandom_range(0, 15) == 0) take_quiet = !take_quiet;
         if (taken == HOLD_AT_COUNT) gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      req_if.valid          = 1'b0;
      req_if.char_code      = '0;
      csr_if.valid          = 1'b0;
      csr_if.text_attribute = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed part, walking through attribute reset value, all ones, all zeros
      foreach (reset_attr_chars[i]) send_char(reset_attr_chars[i]);
      write_attribute(8'hff);
      foreach (full_attr_chars[i]) send_char(full_attr_chars[i]);
      write_attribute(8'h00);
      foreach (zero_attr_chars[i]) send_char(zero_attr_chars[i]);

      // random part in two phases with random attributes; each phase feeds
      // enough lines to keep the row past the visible rows, so the screen scrolls
      write_attribute(tcw_pkg::ATTR_W'($urandom));
      send_random_text(110, 25);
      write_attribute(tcw_pkg::ATTR_W'($urandom));
      send_random_text(110, 25);

      // drain, then leave time for any stray result to show up
      req_if.valid <= 1'b0;
      while (writes_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_req_if.sv
hw/rtl/tcw_rsp_if.sv
hw/rtl/tcw_csr_if.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_queue.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_char_writer.sv
verif/tcw_checker.sv
verif/testbench.sv
